>>> src/hapg_pkg.sv
`timescale 1ns / 1ps
package hapg_pkg;

  typedef struct packed {
    logic [7:0] accent_red;
    logic [7:0] accent_green;
    logic [7:0] accent_blue;
    logic [7:0] accent_alpha;
    logic       dark_mode;
  } in_t;

  typedef struct packed {
    logic [3:0] entry_index;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       last_entry;
  } out_t;

  typedef struct packed {
    logic [3:0] entry_index;
    logic       bypass;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last_entry;
  } side_t;

  typedef enum logic [2:0] {
    F_IDLE, F_CONV, F_FIX, F_PREP, F_DIV, F_HUEA, F_HUEB, F_DONE
  } front_state_e;

  typedef enum logic [1:0] {
    HUE_RAMP, HUE_HIGH, HUE_LOW
  } hue_region_e;

  typedef enum logic [1:0] {
    ROLE_BACKGROUND, ROLE_FOREGROUND, ROLE_SURFACE, ROLE_BORDER
  } role_e;

  localparam logic [3:0] ENTRY_ACCENT     = 4'd0;
  localparam logic [3:0] ENTRY_WHITE      = 4'd1;
  localparam logic [3:0] ENTRY_LIGHT_BASE = 4'd6;
  localparam logic [3:0] ENTRY_LAST       = 4'd9;
  localparam logic [7:0] BYTE_MAX         = 8'hFF;
  localparam int         DIV_STEPS        = 4;

endpackage

>>> src/hsl_accent_palette_generator_top.sv
`timescale 1ns / 1ps
// Channel  Handshake                Payload
// input    in_valid_i / in_ready_o   in_req_i  (in_t)
// output   out_valid_o / out_ready_i out_req_o (out_t)
//
// Each accent request yields ten palette requests, one per cycle when the output is free.
// A new accent is taken and converted by the radix-16 saturation and hue dividers while
// the palette of the previous accent is still being emitted.
// Reset clears all valid flags and the sequencer; there is no clearing pass.
// A stalled output freezes the entry pipeline while the next accent is still converted.
module hsl_accent_palette_generator_top import hapg_pkg::*; #(
  parameter int FRACTION_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_req_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_req_o
);

  localparam int FB = FRACTION_BITS;
  localparam int W  = FB + 1;
  localparam longint OneL = longint'(1) << FB;
  localparam logic [W-1:0] Sat15 = W'((15 * OneL + 50) / 100);
  localparam logic [W-1:0] Sat20 = W'((20 * OneL + 50) / 100);
  localparam logic [W-1:0] Sat25 = W'((25 * OneL + 50) / 100);
  localparam logic [W-1:0] Lv10  = W'((10 * OneL + 50) / 100);
  localparam logic [W-1:0] Lv18  = W'((18 * OneL + 50) / 100);
  localparam logic [W-1:0] Lv26  = W'((26 * OneL + 50) / 100);
  localparam logic [W-1:0] Lv82  = W'((82 * OneL + 50) / 100);
  localparam logic [W-1:0] Lv88  = W'((88 * OneL + 50) / 100);
  localparam logic [W-1:0] Lv94  = W'((94 * OneL + 50) / 100);
  localparam logic [W-1:0] Lv96  = W'((96 * OneL + 50) / 100);

  logic          ibuf_v_q;
  in_t           ibuf_q;
  logic          front_ready, front_valid, front_take;
  logic [FB-1:0] front_h;
  logic [W-1:0]  front_s;
  in_t           front_req;

  logic          emit_v_q;
  logic [3:0]    emit_cnt_q;
  logic [FB-1:0] emit_h_q;
  logic [W-1:0]  emit_s_q;
  in_t           emit_item_q;
  logic          emit_done, pipe_ready;
  side_t         side;
  role_e         role;
  logic          themed;
  logic [W-1:0]  sat_sel, lev_sel;

  assign in_ready_o = !ibuf_v_q || front_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ibuf_v_q <= 1'b0;
    end else if (in_ready_o) begin
      ibuf_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) ibuf_q <= in_req_i;
  end

  hapg_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
    .clk_i,
    .rst_ni,
    .req_valid_i (ibuf_v_q),
    .req_ready_o (front_ready),
    .req_i       (ibuf_q),
    .res_valid_o (front_valid),
    .res_ready_i (front_take),
    .res_h_o     (front_h),
    .res_s_o     (front_s),
    .res_req_o   (front_req)
  );

  assign emit_done  = emit_v_q && pipe_ready && (emit_cnt_q == ENTRY_LAST);
  assign front_take = !emit_v_q || emit_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_v_q   <= 1'b0;
      emit_cnt_q <= ENTRY_ACCENT;
    end else if (front_take) begin
      emit_v_q   <= front_valid;
      emit_cnt_q <= ENTRY_ACCENT;
    end else if (pipe_ready) begin
      emit_cnt_q <= emit_cnt_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (front_take && front_valid) begin
      emit_h_q    <= front_h;
      emit_s_q    <= front_s;
      emit_item_q <= front_req;
    end
  end

  always_comb begin
    role   = role_e'(emit_cnt_q[1:0] + 2'd2);
    themed = (emit_cnt_q < ENTRY_LIGHT_BASE) && emit_item_q.dark_mode;
    unique case (role)
      ROLE_BACKGROUND: begin sat_sel = Sat15; lev_sel = themed ? Lv10 : Lv96; end
      ROLE_FOREGROUND: begin sat_sel = Sat15; lev_sel = themed ? Lv88 : Lv10; end
      ROLE_SURFACE:    begin sat_sel = Sat20; lev_sel = themed ? Lv18 : Lv94; end
      ROLE_BORDER:     begin sat_sel = Sat25; lev_sel = themed ? Lv26 : Lv82; end
      default:         begin sat_sel = Sat15; lev_sel = Lv96; end
    endcase
    side.entry_index = emit_cnt_q;
    side.last_entry  = (emit_cnt_q == ENTRY_LAST);
    side.bypass      = (emit_cnt_q == ENTRY_ACCENT) || (emit_cnt_q == ENTRY_WHITE);
    if (emit_cnt_q == ENTRY_ACCENT) begin
      side.red   = emit_item_q.accent_red;
      side.green = emit_item_q.accent_green;
      side.blue  = emit_item_q.accent_blue;
      side.alpha = emit_item_q.accent_alpha;
    end else begin
      side.red   = BYTE_MAX;
      side.green = BYTE_MAX;
      side.blue  = BYTE_MAX;
      side.alpha = BYTE_MAX;
    end
  end

  hapg_entry_pipe #(.FRACTION_BITS(FRACTION_BITS)) u_pipe (
    .clk_i,
    .rst_ni,
    .in_valid_i  (emit_v_q),
    .in_ready_o  (pipe_ready),
    .side_i      (side),
    .h_i         (emit_h_q),
    .s_i         (emit_s_q),
    .sat_i       (sat_sel),
    .lev_i       (lev_sel),
    .out_valid_o,
    .out_ready_i,
    .out_req_o
  );

`ifndef ASSERT_OFF
  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_req_o.entry_index <= ENTRY_LAST)
    else $error("palette index out of range");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_req_o.last_entry == (out_req_o.entry_index == ENTRY_LAST)))
    else $error("last flag does not match index");

  a_emit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_v_q |-> emit_cnt_q <= ENTRY_LAST)
    else $error("entry counter overran");

  a_buffer_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> ibuf_v_q)
    else $error("input stalled with empty buffer");
`endif

endmodule

>>> src/hapg_front.sv
`timescale 1ns / 1ps
module hapg_front import hapg_pkg::*; #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     req_valid_i,
  output logic                     req_ready_o,
  input  in_t                      req_i,
  output logic                     res_valid_o,
  input  logic                     res_ready_i,
  output logic [FRACTION_BITS-1:0] res_h_o,
  output logic [FRACTION_BITS:0]   res_s_o,
  output in_t                      res_req_o
);

  localparam int FB = FRACTION_BITS;
  localparam int W  = FB + 1;
  localparam int CW = $clog2(W + 1);
  localparam longint OneL = longint'(1) << FB;
  localparam logic [W-1:0]   Half   = W'(OneL / 2);
  localparam logic [W:0]     TwoOne = (W + 1)'(2 * OneL);
  localparam logic [FB+8:0]  Mb     = (FB + 9)'((longint'(1) << (FB + 16)) / 255);
  localparam logic [FB+3:0]  M6     = (FB + 4)'((longint'(1) << (FB + 6)) / 6);
  localparam logic [CW-1:0]  NSteps = CW'(W);

  front_state_e state_q, state_d;

  in_t              item_q;
  logic [W-1:0]     q0_q [3];
  logic [W-1:0]     frac_q [3];
  logic [W+1:0]     srem_q, hrem_q;
  logic [W:0]       sdiv_q;
  logic [W-1:0]     hdiv_q;
  logic [W-1:0]     squo_q, hquo_q;
  logic [2:0]       hk_q;
  logic             hneg_q, grey_q;
  logic [CW-1:0]    left_q;
  logic [FB+2:0]    hs_q;
  logic [2*FB+6:0]  h6p_q;
  logic [FB-1:0]    res_h_q;
  logic [W-1:0]     res_s_q;

  logic             take;
  logic [7:0]       byte_in [3];
  logic [W-1:0]     q0_d [3];
  logic [W-1:0]     frac_d [3];
  logic [W-1:0]     mx, mn, dd, num;
  logic [W:0]       sum, denom;
  logic [W-1:0]     lval;
  logic [2:0]       hk_d;
  logic             hneg_d;
  logic [W+1:0]     sr, hr;
  logic [W-1:0]     sq, hq;
  logic [CW-1:0]    left_d;
  logic [FB+2:0]    hs_d;
  logic [W-1:0]     hq0;
  logic [FB+2:0]    hrr;
  logic [W-1:0]     hfin;

  assign take        = req_valid_i && req_ready_o;
  assign req_ready_o = (state_q == F_IDLE) || (state_q == F_DONE && res_ready_i);
  assign res_valid_o = (state_q == F_DONE);
  assign res_h_o     = res_h_q;
  assign res_s_o     = res_s_q;
  assign res_req_o   = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE: begin
        if (take) state_d = F_CONV;
      end
      F_CONV: state_d = F_FIX;
      F_FIX:  state_d = F_PREP;
      F_PREP: state_d = F_DIV;
      F_DIV: begin
        if (left_d == '0) state_d = F_HUEA;
      end
      F_HUEA: state_d = F_HUEB;
      F_HUEB: state_d = F_DONE;
      F_DONE: begin
        if (res_ready_i) state_d = take ? F_CONV : F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  assign byte_in[0] = item_q.accent_red;
  assign byte_in[1] = item_q.accent_green;
  assign byte_in[2] = item_q.accent_blue;

  always_comb begin
    logic [FB+16:0] prod;
    logic [FB+8:0]  rem;
    for (int c = 0; c < 3; c++) begin
      prod      = (FB + 17)'(byte_in[c]) * (FB + 17)'(Mb);
      q0_d[c]   = W'(prod >> 16);
      rem       = (FB + 9)'({byte_in[c], {FB{1'b0}}}) - (FB + 9)'(q0_q[c]) * (FB + 9)'(255);
      frac_d[c] = (rem >= (FB + 9)'(255)) ? q0_q[c] + W'(1) : q0_q[c];
    end
  end

  always_comb begin
    logic [W-1:0] r, g, b;
    r = frac_q[0];
    g = frac_q[1];
    b = frac_q[2];
    mx = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
    mn = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
    sum   = {1'b0, mx} + {1'b0, mn};
    lval  = W'(sum >> 1);
    dd    = mx - mn;
    denom = (lval > Half) ? TwoOne - sum : sum;
    if (mx == r) begin
      if (g >= b) begin
        hk_d = 3'd0; hneg_d = 1'b0; num = g - b;
      end else begin
        hk_d = 3'd6; hneg_d = 1'b1; num = b - g;
      end
    end else if (mx == g) begin
      hk_d = 3'd2;
      if (b >= r) begin
        hneg_d = 1'b0; num = b - r;
      end else begin
        hneg_d = 1'b1; num = r - b;
      end
    end else begin
      hk_d = 3'd4;
      if (r >= g) begin
        hneg_d = 1'b0; num = r - g;
      end else begin
        hneg_d = 1'b1; num = g - r;
      end
    end
  end

  always_comb begin
    sr = srem_q;
    hr = hrem_q;
    sq = squo_q;
    hq = hquo_q;
    for (int j = 0; j < DIV_STEPS; j++) begin
      if (CW'(j) < left_q) begin
        if (sr >= (W + 2)'(sdiv_q)) begin
          sr = sr - (W + 2)'(sdiv_q);
          sq = {sq[W-2:0], 1'b1};
        end else begin
          sq = {sq[W-2:0], 1'b0};
        end
        sr = {sr[W:0], 1'b0};
        if (hr >= (W + 2)'(hdiv_q)) begin
          hr = hr - (W + 2)'(hdiv_q);
          hq = {hq[W-2:0], 1'b1};
        end else begin
          hq = {hq[W-2:0], 1'b0};
        end
        hr = {hr[W:0], 1'b0};
      end
    end
    left_d = (left_q > CW'(DIV_STEPS)) ? left_q - CW'(DIV_STEPS) : '0;
  end

  always_comb begin
    if (hneg_q) begin
      hs_d = {hk_q, {FB{1'b0}}} - (FB + 3)'(hquo_q);
    end else begin
      hs_d = {hk_q, {FB{1'b0}}} + (FB + 3)'(hquo_q);
    end
    hq0  = W'(h6p_q >> (FB + 6));
    hrr  = hs_q - (FB + 3)'(hq0) * (FB + 3)'(6);
    hfin = (hrr >= (FB + 3)'(6)) ? hq0 + W'(1) : hq0;
  end

  always_ff @(posedge clk_i) begin
    if (take) item_q <= req_i;
    unique case (state_q)
      F_CONV: q0_q <= q0_d;
      F_FIX:  frac_q <= frac_d;
      F_PREP: begin
        srem_q <= (W + 2)'(dd);
        sdiv_q <= denom;
        hrem_q <= (W + 2)'(num);
        hdiv_q <= dd;
        squo_q <= '0;
        hquo_q <= '0;
        hk_q   <= hk_d;
        hneg_q <= hneg_d;
        grey_q <= (mx == mn);
        left_q <= NSteps;
      end
      F_DIV: begin
        srem_q <= sr;
        hrem_q <= hr;
        squo_q <= sq;
        hquo_q <= hq;
        left_q <= left_d;
      end
      F_HUEA: begin
        hs_q  <= hs_d;
        h6p_q <= (2 * FB + 7)'(hs_d) * (2 * FB + 7)'(M6);
      end
      F_HUEB: begin
        res_h_q <= grey_q ? '0 : hfin[FB-1:0];
        res_s_q <= grey_q ? '0 : squo_q;
      end
      default: ;
    endcase
  end

endmodule

>>> src/hapg_entry_pipe.sv
`timescale 1ns / 1ps
module hapg_entry_pipe import hapg_pkg::*; #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  side_t                    side_i,
  input  logic [FRACTION_BITS-1:0] h_i,
  input  logic [FRACTION_BITS:0]   s_i,
  input  logic [FRACTION_BITS:0]   sat_i,
  input  logic [FRACTION_BITS:0]   lev_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output out_t                     out_req_o
);

  localparam int FB = FRACTION_BITS;
  localparam int W  = FB + 1;
  localparam longint OneL = longint'(1) << FB;
  localparam logic [W-1:0] One    = W'(OneL);
  localparam logic [W-1:0] Half   = W'(OneL / 2);
  localparam logic [W-1:0] Third  = W'((OneL + 1) / 3);
  localparam logic [W-1:0] Sixth  = W'((OneL + 3) / 6);
  localparam logic [W-1:0] Third2 = W'((2 * OneL + 1) / 3);

  logic en;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  side_t side1_q, side2_q, side3_q, side4_q, side5_q;
  logic [FB-1:0] h1_q, h2_q;
  logic [W-1:0]  l1_q, l2_q, l3_q, l4_q;
  logic [W-1:0]  ss1_q, q2_q, p3_q, q3_q, dq3_q, p4_q, q4_q;
  logic          z2_q, z3_q, z4_q;
  logic [W-1:0]  t3_q [3];
  hue_region_e   rg4_q [3];
  logic [W:0]    ramp4_q [3];
  logic [W-1:0]  val5_q [3];
  out_t          out_q;

  logic [2*W-1:0] ss_full;
  logic [W:0]     mop;
  logic [2*W:0]   qprod;
  logic [W+1:0]   qraw;
  logic [W-1:0]   q2_d;
  logic [W:0]     two_l, pw;
  logic [W-1:0]   p3_d;
  logic [W:0]     tr;
  logic [W-1:0]   t3_d [3];
  hue_region_e    rg4_d [3];
  logic [W:0]     ramp4_d [3];
  logic [W-1:0]   val5_d [3];
  logic [7:0]     byte6 [3];

  assign en          = !v6_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = v6_q;
  assign out_req_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0;
      v4_q <= 1'b0; v5_q <= 1'b0; v6_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i; v2_q <= v1_q; v3_q <= v2_q;
      v4_q <= v3_q; v5_q <= v4_q; v6_q <= v5_q;
    end
  end

  assign ss_full = s_i * sat_i;

  always_comb begin
    mop   = (l1_q < Half) ? {1'b0, One} + {1'b0, ss1_q} : {1'b0, ss1_q};
    qprod = (2 * W + 1)'(l1_q) * (2 * W + 1)'(mop);
    if (l1_q < Half) begin
      qraw = (W + 2)'(qprod >> FB);
    end else begin
      qraw = (W + 2)'(l1_q) + (W + 2)'(ss1_q) - (W + 2)'(qprod >> FB);
    end
    q2_d = (qraw > (W + 2)'(One)) ? One : qraw[W-1:0];
  end

  always_comb begin
    two_l = {l2_q, 1'b0};
    pw    = (two_l > {1'b0, q2_q}) ? two_l - {1'b0, q2_q} : '0;
    p3_d  = (pw > {1'b0, q2_q}) ? q2_q : pw[W-1:0];
    tr    = {2'b0, h2_q} + {1'b0, Third};
    t3_d[0] = (tr > {1'b0, One}) ? W'(tr - {1'b0, One}) : tr[W-1:0];
    t3_d[1] = {1'b0, h2_q};
    t3_d[2] = ({1'b0, h2_q} < Third) ? {1'b0, h2_q} + One - Third : {1'b0, h2_q} - Third;
  end

  always_comb begin
    logic [W-1:0]   f;
    logic [W+1:0]   f6;
    logic [2*W+1:0] prod;
    for (int c = 0; c < 3; c++) begin
      if (t3_q[c] < Sixth) begin
        rg4_d[c] = HUE_RAMP; f = t3_q[c];
      end else if (t3_q[c] < Half) begin
        rg4_d[c] = HUE_HIGH; f = '0;
      end else if (t3_q[c] < Third2) begin
        rg4_d[c] = HUE_RAMP; f = Third2 - t3_q[c];
      end else begin
        rg4_d[c] = HUE_LOW; f = '0;
      end
      f6   = (W + 2)'(f) * (W + 2)'(6);
      prod = (2 * W + 2)'(dq3_q) * (2 * W + 2)'(f6);
      ramp4_d[c] = (W + 1)'(prod >> FB);
    end
  end

  always_comb begin
    logic [W+1:0] sum;
    for (int c = 0; c < 3; c++) begin
      sum = (W + 2)'(p4_q) + (W + 2)'(ramp4_q[c]);
      if (z4_q) begin
        val5_d[c] = l4_q;
      end else begin
        case (rg4_q[c])
          HUE_RAMP: val5_d[c] = (sum > (W + 2)'(One)) ? One : sum[W-1:0];
          HUE_HIGH: val5_d[c] = q4_q;
          default:  val5_d[c] = p4_q;
        endcase
      end
    end
  end

  always_comb begin
    logic [W+7:0] scaled;
    logic [8:0]   bw;
    for (int c = 0; c < 3; c++) begin
      scaled   = {val5_q[c], 8'b0} - (W + 8)'(val5_q[c]);
      bw       = 9'(scaled >> FB);
      byte6[c] = (bw > 9'(BYTE_MAX)) ? BYTE_MAX : bw[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side1_q <= side_i;
      h1_q    <= h_i;
      l1_q    <= lev_i;
      ss1_q   <= W'(ss_full >> FB);

      side2_q <= side1_q;
      h2_q    <= h1_q;
      l2_q    <= l1_q;
      q2_q    <= q2_d;
      z2_q    <= (ss1_q == '0);

      side3_q <= side2_q;
      l3_q    <= l2_q;
      p3_q    <= p3_d;
      q3_q    <= q2_q;
      dq3_q   <= q2_q - p3_d;
      z3_q    <= z2_q;
      t3_q    <= t3_d;

      side4_q <= side3_q;
      l4_q    <= l3_q;
      p4_q    <= p3_q;
      q4_q    <= q3_q;
      z4_q    <= z3_q;
      rg4_q   <= rg4_d;
      ramp4_q <= ramp4_d;

      side5_q <= side4_q;
      val5_q  <= val5_d;

      out_q.entry_index <= side5_q.entry_index;
      out_q.out_red     <= side5_q.bypass ? side5_q.red : byte6[0];
      out_q.out_green   <= side5_q.bypass ? side5_q.green : byte6[1];
      out_q.out_blue    <= side5_q.bypass ? side5_q.blue : byte6[2];
      out_q.out_alpha   <= side5_q.alpha;
      out_q.last_entry  <= side5_q.last_entry;
    end
  end

endmodule

>>> bench/hsl_accent_palette_generator_top_test.sv
`timescale 1ns / 1ps
module hsl_accent_palette_generator_top_test;
  import hapg_pkg::*;

  localparam int FB = 16;
  localparam longint ONE = 64'sd1 << FB;
  localparam int LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_req = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_req;

  int errors = 0;
  int cycles = 0;
  bit calm = 1'b0;
  bit hold_off = 1'b0;

  hsl_accent_palette_generator_top #(.FRACTION_BITS(FB)) i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_req_i(in_req),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_req_o(out_req)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic longint pct(input longint c);
    return (c * ONE + 50) / 100;
  endfunction

  function automatic longint clampf(input longint v);
    if (v < 0) return 0;
    if (v > ONE) return ONE;
    return v;
  endfunction

  function automatic logic [7:0] fx_to_byte(input longint v);
    longint b;
    b = (clampf(v) * 255) >>> FB;
    return (b > 255) ? 8'd255 : b[7:0];
  endfunction

  function automatic longint hue_level(input longint p, input longint q, input longint t0);
    longint t, th2, sx;
    t = t0;
    th2 = (2 * ONE + 1) / 3;
    sx = (ONE + 3) / 6;
    if (t < 0) t += ONE;
    if (t > ONE) t -= ONE;
    if (t < sx) return clampf(p + (((q - p) * 6 * t) >>> FB));
    if (t < ONE / 2) return q;
    if (t < th2) return clampf(p + (((q - p) * 6 * (th2 - t)) >>> FB));
    return p;
  endfunction

  class palette_board;
    out_t pending[$];

    function void note_accent(in_t a);
      longint r, g, b, mx, mn, l, h, s, d, hs, ss, lev, q, p, th;
      longint sat[4], dl[4], ll[4];
      out_t e;
      sat = '{15, 15, 20, 25};
      dl = '{10, 88, 18, 26};
      ll = '{96, 10, 94, 82};
      th = (ONE + 1) / 3;
      r = (longint'(a.accent_red) << FB) / 255;
      g = (longint'(a.accent_green) << FB) / 255;
      b = (longint'(a.accent_blue) << FB) / 255;
      mx = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
      mn = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
      l = (mx + mn) / 2;
      h = 0;
      s = 0;
      if (mx != mn) begin
        d = mx - mn;
        s = (l > ONE / 2) ? (d * ONE) / (2 * ONE - mx - mn) : (d * ONE) / (mx + mn);
        s = clampf(s);
        if (mx == r) hs = (g >= b) ? ((g - b) * ONE) / d : 6 * ONE - ((b - g) * ONE) / d;
        else if (mx == g) hs = (b >= r) ? 2 * ONE + ((b - r) * ONE) / d
                                        : 2 * ONE - ((r - b) * ONE) / d;
        else hs = (r >= g) ? 4 * ONE + ((r - g) * ONE) / d : 4 * ONE - ((g - r) * ONE) / d;
        h = hs / 6;
      end
      for (int k = 0; k < 10; k++) begin
        e = '0;
        e.entry_index = k[3:0];
        e.out_alpha = BYTE_MAX;
        e.last_entry = (k[3:0] == ENTRY_LAST);
        if (k[3:0] == ENTRY_ACCENT) begin
          e.out_red = a.accent_red;
          e.out_green = a.accent_green;
          e.out_blue = a.accent_blue;
          e.out_alpha = a.accent_alpha;
        end else if (k[3:0] == ENTRY_WHITE) begin
          e.out_red = BYTE_MAX;
          e.out_green = BYTE_MAX;
          e.out_blue = BYTE_MAX;
        end else begin
          lev = pct((k < ENTRY_LIGHT_BASE && a.dark_mode) ? dl[(k - 2) & 3] : ll[(k - 2) & 3]);
          ss = (s * pct(sat[(k - 2) & 3])) >>> FB;
          if (ss == 0) begin
            e.out_red = fx_to_byte(lev);
            e.out_green = e.out_red;
            e.out_blue = e.out_red;
          end else begin
            q = (lev < ONE / 2) ? (lev * (ONE + ss)) >>> FB : lev + ss - ((lev * ss) >>> FB);
            q = clampf(q);
            p = 2 * lev - q;
            if (p < 0) p = 0;
            if (p > q) p = q;
            e.out_red = fx_to_byte(hue_level(p, q, h + th));
            e.out_green = fx_to_byte(hue_level(p, q, h));
            e.out_blue = fx_to_byte(hue_level(p, q, h - th));
          end
        end
        pending.push_back(e);
      end
    endfunction

    task check_entry(out_t got);
      out_t w;
      if (pending.size() == 0) begin
        report("unexpected entry", got.entry_index, -1);
        return;
      end
      w = pending.pop_front();
      if (got.entry_index != w.entry_index) report("entry_index", got.entry_index, w.entry_index);
      if (got.out_red != w.out_red) report("out_red", got.out_red, w.out_red);
      if (got.out_green != w.out_green) report("out_green", got.out_green, w.out_green);
      if (got.out_blue != w.out_blue) report("out_blue", got.out_blue, w.out_blue);
      if (got.out_alpha != w.out_alpha) report("out_alpha", got.out_alpha, w.out_alpha);
      if (got.last_entry != w.last_entry) report("last_entry", got.last_entry, w.last_entry);
    endtask
  endclass

  palette_board board = new();

  always @(posedge clk) begin
    cycles++;
    if (rst_n && in_valid && in_ready) board.note_accent(in_req);
    if (rst_n && out_valid && out_ready) board.check_entry(out_req);
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** hsl_accent_palette_generator_top: FAILED **");
      $finish;
    end
  end

  // Output side: random stall bursts, plus one long hold-off stretch.
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
        n = 0;
        while (n < 300) begin
          @(negedge clk);
          n++;
        end
        hold_off = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_accent(input in_t a);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_req <= a;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_colour(input int r, input int g, input int b, input int a,
                             input bit dk);
    in_t x;
    x.accent_red = r[7:0];
    x.accent_green = g[7:0];
    x.accent_blue = b[7:0];
    x.accent_alpha = a[7:0];
    x.dark_mode = dk;
    send_accent(x);
  endtask

  task automatic send_random();
    in_t x;
    logic [63:0] rnd;
    rnd = {$urandom, $urandom};
    x = rnd[$bits(in_t)-1:0];
    case ($urandom_range(0, 5))
      0: begin
        x.accent_green = x.accent_red;
        x.accent_blue = x.accent_red;
      end
      1: x.accent_blue = x.accent_red;
      2: x.accent_red = ($urandom_range(0, 1)) ? 8'hFF : 8'h00;
      default: ;
    endcase
    send_accent(x);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    for (int dk = 0; dk < 2; dk++) begin
      send_colour(0, 0, 0, 0, dk);
      send_colour(255, 255, 255, 255, dk);
      send_colour(128, 128, 128, 200, dk);
      send_colour(255, 0, 0, 255, dk);
      send_colour(0, 255, 0, 17, dk);
      send_colour(0, 0, 255, 255, dk);
      send_colour(255, 0, 255, 255, dk);
      send_colour(255, 255, 0, 255, dk);
      send_colour(0, 255, 255, 1, dk);
      send_colour(1, 0, 0, 255, dk);
      send_colour(254, 255, 255, 255, dk);
    end
    hold_off = 1'b1;
    for (int i = 0; i < 460; i++) begin
      if (i == 400) calm = 1'b1;
      send_random();
    end
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("** hsl_accent_palette_generator_top: PASSED **");
    end else begin
      $display("** hsl_accent_palette_generator_top: FAILED **");
    end
    $finish;
  end

endmodule
